// ===== hw/rtl/hsvrgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// hue geometry
	localparam int unsigned HUE_W      = 9;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned REM_W      = 6;
	localparam int unsigned FULL_TURN  = 360;
	localparam int unsigned SECTOR_DEG = 60;

	// reciprocal of sixty, exact for products below 15360
	localparam int unsigned RECIP_60    = 17477;
	localparam int unsigned RECIP_W     = 15;
	localparam int unsigned RECIP_SHIFT = 20;

	// product widths
	localparam int unsigned PROD_VS_W = 2 * CHAN_W;
	localparam int unsigned PROD_CF_W = CHAN_W + REM_W;

	// hue sector, named by the leading channel then the one that moves
	typedef enum logic [2:0] {
		SEC_R_G = 3'd0,
		SEC_G_R = 3'd1,
		SEC_G_B = 3'd2,
		SEC_B_G = 3'd3,
		SEC_B_R = 3'd4,
		SEC_R_B = 3'd5
	} sector_t;

	// payload from the front end to the secondary component stages
	typedef struct packed {
		sector_t             sector;
		logic [REM_W-1:0]    factor;
		logic [CHAN_W-1:0]   chroma;
		logic [CHAN_W-1:0]   offset;
	} front_t;

	// payload from the secondary component stages to the mixer
	typedef struct packed {
		sector_t             sector;
		logic [CHAN_W-1:0]   chroma;
		logic [CHAN_W-1:0]   second;
		logic [CHAN_W-1:0]   offset;
	} comp_t;

	// pixel as handed in
	typedef struct packed {
		logic [CHAN_W-1:0]   brightness;
		logic [CHAN_W-1:0]   saturation;
		logic [HUE_W-1:0]    hue;
	} hsv_t;

	// pixel as handed out
	typedef struct packed {
		logic [CHAN_W-1:0]   blue;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   red;
	} rgb_t;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb pixel converter
//
// channel  dir  tdata fields (lsb first)                       role
// s_axis   in   hue[8:0] saturation[16:9] brightness[24:17]    hsv pixel beat
// m_axis   out  red[7:0] green[15:8] blue[23:16]               rgb pixel beat
//
// one pixel per clock sustained while the output is ready, each beat passing stages s1 to s5 in order
// the five register stages each carry a valid bit with their own ready chain
// a stalled output holds its beat while empty stages upstream keep filling
// reset clears the valid bits only, payload registers are left as they are
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // hue[8:0], saturation[16:9], brightness[24:17]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

	hsvrgb_pkg::hsv_t   in_pix;
	hsvrgb_pkg::front_t front_data;
	hsvrgb_pkg::comp_t  comp_data;
	hsvrgb_pkg::rgb_t   out_pix;
	logic               front_valid, front_ready;
	logic               comp_valid, comp_ready;

	// unpack input beat, padding bits ignored
	assign in_pix = s_axis_tdata[24:0];

	hsvrgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pix    (in_pix),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	hsvrgb_second u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (comp_valid),
		.out_ready (comp_ready),
		.out_data  (comp_data)
	);

	hsvrgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (comp_valid),
		.in_ready  (comp_ready),
		.in_data   (comp_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix)
	);

	assign m_axis_tdata = out_pix;

endmodule

// ===== hw/rtl/hsvrgb_front.sv =====
// front end: hue sector decode, value times saturation, chroma and offset
`timescale 1ns / 1ps

module hsvrgb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvrgb_pkg::hsv_t    in_pix,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvrgb_pkg::front_t  out_data
);

	localparam logic [hsvrgb_pkg::HUE_W-1:0] TURN =
		hsvrgb_pkg::HUE_W'(hsvrgb_pkg::FULL_TURN);
	localparam logic [hsvrgb_pkg::HUE_W-1:0] B1 =
		hsvrgb_pkg::HUE_W'(hsvrgb_pkg::SECTOR_DEG);
	localparam logic [hsvrgb_pkg::HUE_W-1:0] B2 =
		hsvrgb_pkg::HUE_W'(2 * hsvrgb_pkg::SECTOR_DEG);
	localparam logic [hsvrgb_pkg::HUE_W-1:0] B3 =
		hsvrgb_pkg::HUE_W'(3 * hsvrgb_pkg::SECTOR_DEG);
	localparam logic [hsvrgb_pkg::HUE_W-1:0] B4 =
		hsvrgb_pkg::HUE_W'(4 * hsvrgb_pkg::SECTOR_DEG);
	localparam logic [hsvrgb_pkg::HUE_W-1:0] B5 =
		hsvrgb_pkg::HUE_W'(5 * hsvrgb_pkg::SECTOR_DEG);
	localparam logic [hsvrgb_pkg::REM_W-1:0] DEG =
		hsvrgb_pkg::REM_W'(hsvrgb_pkg::SECTOR_DEG);

	logic                                 valid_s1, valid_s2;
	logic                                 ready_s1, ready_s2;
	hsvrgb_pkg::sector_t                  sector_s1;
	logic [hsvrgb_pkg::REM_W-1:0]         rem_s1;
	logic [hsvrgb_pkg::PROD_VS_W-1:0]     prod_s1;
	logic [hsvrgb_pkg::CHAN_W-1:0]        bright_s1;
	hsvrgb_pkg::front_t                   data_s2;

	logic [hsvrgb_pkg::HUE_W-1:0]         hue_wrap;
	logic [hsvrgb_pkg::HUE_W-1:0]         hue_base;
	logic [hsvrgb_pkg::HUE_W-1:0]         hue_rem;
	hsvrgb_pkg::sector_t                  sector_d;
	logic [hsvrgb_pkg::PROD_VS_W:0]       div_sum;
	logic [hsvrgb_pkg::CHAN_W-1:0]        chroma_d;

	// stage ready chain
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// wrap out-of-range hue, then find the sixty degree sector
	always_comb begin
		hue_wrap = (in_pix.hue >= TURN) ? in_pix.hue - TURN : in_pix.hue;
		priority if (hue_wrap >= B5) begin
			sector_d = hsvrgb_pkg::SEC_R_B;
			hue_base = B5;
		end else if (hue_wrap >= B4) begin
			sector_d = hsvrgb_pkg::SEC_B_R;
			hue_base = B4;
		end else if (hue_wrap >= B3) begin
			sector_d = hsvrgb_pkg::SEC_B_G;
			hue_base = B3;
		end else if (hue_wrap >= B2) begin
			sector_d = hsvrgb_pkg::SEC_G_B;
			hue_base = B2;
		end else if (hue_wrap >= B1) begin
			sector_d = hsvrgb_pkg::SEC_G_R;
			hue_base = B1;
		end else begin
			sector_d = hsvrgb_pkg::SEC_R_G;
			hue_base = '0;
		end
		hue_rem = hue_wrap - hue_base;
	end

	// stage 1: sector, remainder and value times saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sector_s1 <= sector_d;
			rem_s1    <= hue_rem[hsvrgb_pkg::REM_W-1:0];
			prod_s1   <= in_pix.brightness * in_pix.saturation;
			bright_s1 <= in_pix.brightness;
		end
	end

	// divide by 255: (p + 1 + p/256) / 256 is exact over the product range
	always_comb begin
		div_sum  = {1'b0, prod_s1} + (hsvrgb_pkg::PROD_VS_W + 1)'(1)
			+ {9'd0, prod_s1[hsvrgb_pkg::PROD_VS_W-1:8]};
		chroma_d = div_sum[hsvrgb_pkg::CHAN_W+7:8];
	end

	// stage 2: chroma, offset and the multiplier for the secondary component
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.sector <= sector_s1;
			data_s2.factor <= sector_s1[0] ? DEG - rem_s1 : rem_s1;
			data_s2.chroma <= chroma_d;
			data_s2.offset <= bright_s1 - chroma_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== hw/rtl/hsvrgb_second.sv =====
// secondary component: chroma times factor, then division by sixty
`timescale 1ns / 1ps

module hsvrgb_second (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvrgb_pkg::front_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvrgb_pkg::comp_t   out_data
);

	localparam int unsigned QPROD_W = hsvrgb_pkg::PROD_CF_W + hsvrgb_pkg::RECIP_W;
	localparam logic [hsvrgb_pkg::RECIP_W-1:0] RECIP =
		hsvrgb_pkg::RECIP_W'(hsvrgb_pkg::RECIP_60);

	logic                                 valid_s3, valid_s4;
	logic                                 ready_s3, ready_s4;
	logic [hsvrgb_pkg::PROD_CF_W-1:0]     prod_s3;
	hsvrgb_pkg::sector_t                  sector_s3;
	logic [hsvrgb_pkg::CHAN_W-1:0]        chroma_s3;
	logic [hsvrgb_pkg::CHAN_W-1:0]        offset_s3;
	hsvrgb_pkg::comp_t                    data_s4;
	logic [QPROD_W-1:0]                   qprod;

	// stage ready chain
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	// stage 3: chroma times remainder factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			prod_s3   <= in_data.chroma * in_data.factor;
			sector_s3 <= in_data.sector;
			chroma_s3 <= in_data.chroma;
			offset_s3 <= in_data.offset;
		end
	end

	// divide by sixty through a scaled reciprocal
	assign qprod = QPROD_W'(prod_s3) * QPROD_W'(RECIP);

	// stage 4: secondary component
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			data_s4.sector <= sector_s3;
			data_s4.chroma <= chroma_s3;
			data_s4.second <= qprod[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CHAN_W];
			data_s4.offset <= offset_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ===== hw/rtl/hsvrgb_mix.sv =====
// channel placement by sector, offset add and output register
`timescale 1ns / 1ps

module hsvrgb_mix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvrgb_pkg::comp_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvrgb_pkg::rgb_t    out_pix
);

	logic                          valid_s5;
	logic                          ready_s5;
	hsvrgb_pkg::rgb_t              pix_s5;
	logic [hsvrgb_pkg::CHAN_W-1:0] r_d, g_d, b_d;

	assign ready_s5 = !valid_s5 || out_ready;
	assign in_ready = ready_s5;

	// place chroma, secondary and zero on the channels
	always_comb begin
		unique case (in_data.sector)
			hsvrgb_pkg::SEC_R_G: begin
				r_d = in_data.chroma; g_d = in_data.second; b_d = '0;
			end
			hsvrgb_pkg::SEC_G_R: begin
				r_d = in_data.second; g_d = in_data.chroma; b_d = '0;
			end
			hsvrgb_pkg::SEC_G_B: begin
				r_d = '0; g_d = in_data.chroma; b_d = in_data.second;
			end
			hsvrgb_pkg::SEC_B_G: begin
				r_d = '0; g_d = in_data.second; b_d = in_data.chroma;
			end
			hsvrgb_pkg::SEC_B_R: begin
				r_d = in_data.second; g_d = '0; b_d = in_data.chroma;
			end
			default: begin
				r_d = in_data.chroma; g_d = '0; b_d = in_data.second;
			end
		endcase
	end

	// stage 5: add offset into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			pix_s5.red   <= r_d + in_data.offset;
			pix_s5.green <= g_d + in_data.offset;
			pix_s5.blue  <= b_d + in_data.offset;
		end
	end

	assign out_valid = valid_s5;
	assign out_pix   = pix_s5;

endmodule

// ===== sim/hsv_to_rgb_converter_test.sv =====
// self-checking stream testbench for the hsv to rgb pixel converter
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;

	localparam int unsigned CHAN_FULL  = 255;
	localparam int unsigned DRAIN_WAIT = 20;
	localparam int unsigned DRAIN_MAX  = 20000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // hue[8:0], saturation[16:9], brightness[24:17]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]

	// idle and stall rates for the current phase, in percent
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// long hold-off request towards the receiver process
	int unsigned hold_len = 0;
	int unsigned hold_seq = 0;

	hsvrgb_pkg::rgb_t rgb_pending[$];
	int unsigned      fault_count = 0;

	hsv_to_rgb_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// expected colour of one hsv pixel
	function automatic hsvrgb_pkg::rgb_t predict_rgb(hsvrgb_pkg::hsv_t px);
		int unsigned         hue_deg;
		int unsigned         sat;
		int unsigned         val;
		int unsigned         chroma;
		int unsigned         rem;
		int unsigned         second;
		int unsigned         offset;
		hsvrgb_pkg::sector_t sec;
		int unsigned         r;
		int unsigned         g;
		int unsigned         b;
		hsvrgb_pkg::rgb_t    res;
		hue_deg = 32'(px.hue);
		sat     = 32'(px.saturation);
		val     = 32'(px.brightness);
		// hues past a full turn wrap once
		if (hue_deg >= hsvrgb_pkg::FULL_TURN) begin
			hue_deg = hue_deg - hsvrgb_pkg::FULL_TURN;
		end
		chroma = (val * sat) / CHAN_FULL;
		sec    = hsvrgb_pkg::sector_t'(hue_deg / hsvrgb_pkg::SECTOR_DEG);
		rem    = hue_deg % hsvrgb_pkg::SECTOR_DEG;
		// secondary component rises in even sectors, falls in odd ones
		if (sec[0] == 1'b0) begin
			second = (chroma * rem) / hsvrgb_pkg::SECTOR_DEG;
		end else begin
			second = (chroma * (hsvrgb_pkg::SECTOR_DEG - rem)) / hsvrgb_pkg::SECTOR_DEG;
		end
		unique case (sec)
			hsvrgb_pkg::SEC_R_G: begin r = chroma; g = second; b = 0;      end
			hsvrgb_pkg::SEC_G_R: begin r = second; g = chroma; b = 0;      end
			hsvrgb_pkg::SEC_G_B: begin r = 0;      g = chroma; b = second; end
			hsvrgb_pkg::SEC_B_G: begin r = 0;      g = second; b = chroma; end
			hsvrgb_pkg::SEC_B_R: begin r = second; g = 0;      b = chroma; end
			default: begin r = chroma; g = 0;      b = second; end
		endcase
		offset    = val - chroma;
		res.red   = hsvrgb_pkg::CHAN_W'(r + offset);
		res.green = hsvrgb_pkg::CHAN_W'(g + offset);
		res.blue  = hsvrgb_pkg::CHAN_W'(b + offset);
		return res;
	endfunction

	// random pixel, mostly legal hues with some wrapped ones and extreme levels
	function automatic hsvrgb_pkg::hsv_t random_pixel();
		hsvrgb_pkg::hsv_t px;
		if ($urandom_range(7, 0) == 0) begin
			px.hue = hsvrgb_pkg::HUE_W'($urandom_range(511, hsvrgb_pkg::FULL_TURN));
		end else begin
			px.hue = hsvrgb_pkg::HUE_W'($urandom_range(hsvrgb_pkg::FULL_TURN - 1, 0));
		end
		case ($urandom_range(9, 0))
			0:       px.saturation = 8'd0;
			1:       px.saturation = 8'd255;
			default: px.saturation = hsvrgb_pkg::CHAN_W'($urandom_range(255, 0));
		endcase
		case ($urandom_range(9, 0))
			0:       px.brightness = 8'd0;
			1:       px.brightness = 8'd255;
			default: px.brightness = hsvrgb_pkg::CHAN_W'($urandom_range(255, 0));
		endcase
		return px;
	endfunction

	task automatic report_fault(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	// offer one pixel beat, with random idle cycles ahead of it
	task automatic send_pixel(input hsvrgb_pkg::hsv_t px);
		while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, px};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_hsv(input int unsigned h, input int unsigned s, input int unsigned v);
		hsvrgb_pkg::hsv_t px;
		px.hue        = hsvrgb_pkg::HUE_W'(h);
		px.saturation = hsvrgb_pkg::CHAN_W'(s);
		px.brightness = hsvrgb_pkg::CHAN_W'(v);
		send_pixel(px);
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	initial begin
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen     = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	// predict on every input beat, compare on every output beat
	always @(posedge clk) begin
		hsvrgb_pkg::rgb_t got;
		hsvrgb_pkg::rgb_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				rgb_pending.insert(rgb_pending.size(),
					predict_rgb(hsvrgb_pkg::hsv_t'(s_axis_tdata[24:0])));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = hsvrgb_pkg::rgb_t'(m_axis_tdata);
				if (rgb_pending.size() == 0) begin
					report_fault($sformatf("unexpected beat %06h", m_axis_tdata));
				end else begin
					want = rgb_pending.pop_front();
					if (got.red !== want.red)
						report_fault($sformatf("red got %0d expected %0d",
							got.red, want.red));
					if (got.green !== want.green)
						report_fault($sformatf("green got %0d expected %0d",
							got.green, want.green));
					if (got.blue !== want.blue)
						report_fault($sformatf("blue got %0d expected %0d",
							got.blue, want.blue));
				end
			end
		end
	end

	// sector edges, wrapped hues, zero saturation and level extremes
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_hsv(0,   255, 255);
		send_hsv(59,  255, 255);
		send_hsv(60,  255, 255);
		send_hsv(119, 255, 255);
		send_hsv(120, 255, 255);
		send_hsv(179, 255, 255);
		send_hsv(180, 255, 255);
		send_hsv(239, 255, 255);
		send_hsv(240, 255, 255);
		send_hsv(299, 255, 255);
		send_hsv(300, 255, 255);
		send_hsv(359, 255, 255);
		send_hsv(360, 255, 255);
		send_hsv(419, 200, 180);
		send_hsv(480, 128, 250);
		send_hsv(511, 255, 255);
		send_hsv(200, 0,   200);
		send_hsv(45,  0,   255);
		send_hsv(330, 255, 0);
		send_hsv(0,   0,   0);
		send_hsv(90,  1,   255);
		send_hsv(270, 255, 1);
		send_hsv(150, 77,  123);
		send_hsv(256, 170, 85);
	endtask

	// random pixels under each idle and stall mix
	task automatic test_random(input int unsigned per_phase);
		int unsigned phase;
		int unsigned n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			for (n = 0; n < per_phase; n++) begin
				send_pixel(random_pixel());
			end
		end
	endtask

	// hold the output off long enough that the pipeline fills and stalls input
	task automatic test_backpressure();
		int unsigned n;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_len = 80;
		hold_seq++;
		for (n = 0; n < 40; n++) begin
			send_pixel(random_pixel());
		end
	endtask

	initial begin
		int unsigned waited;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random(460);

		s_axis_tvalid  <= 1'b0;
		recv_stall_pct = 0;
		waited         = 0;
		while (rgb_pending.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (rgb_pending.size() != 0) begin
			report_fault($sformatf("%0d beats never arrived", rgb_pending.size()));
		end

		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_front.sv
hw/rtl/hsvrgb_second.sv
hw/rtl/hsvrgb_mix.sv
hw/rtl/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_test.sv
